// File: src/sbac_pkg.sv
package sbac_pkg;

    localparam int DEF_CHANNELS = 4;
    localparam int DEF_COLUMNS  = 12;

    localparam int NUM_TERMS   = 6;
    localparam int NUM_DARK    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_RAW_MODE    = 1'b0;
    localparam logic REG_BLACK_LEVEL = 1'b1;

    localparam logic [11:0] BLACK_LEVEL_RESET = 12'd100;

    localparam int TERM_K  = 0;
    localparam int TERM_B  = 1;
    localparam int TERM_K2 = 2;
    localparam int TERM_B2 = 3;
    localparam int TERM_C  = 4;
    localparam int TERM_H  = 5;

    localparam logic [2:0] SEL_LOW_DARK = 3'd6;

    localparam logic [15:0] K_SCALE_M1 = 16'd32767;
    localparam logic [16:0] RECIP_10   = 17'd52429;
    localparam logic [27:0] RECIP_225  = 28'd152709948;
    localparam logic [28:0] SAW_DIV_LO = 29'd225;
    localparam logic [8:0]  SAW_SPAN   = 9'd300;

    localparam int signed LBPC_OVER_HARD  = 275;
    localparam int signed LBPC_OVER       = 255;
    localparam int signed LBPC_OVER_SOFT  = 191;
    localparam int signed LBPC_UNDER_HARD = -20;
    localparam int signed LBPC_UNDER      = 0;
    localparam int signed LBPC_UNDER_SOFT = 64;
    localparam int signed QERR_1          = 28;
    localparam int signed QERR_2          = 52;
    localparam int signed QERR_3          = 96;

    localparam logic [3:0] FAULT_NONE    = 4'd0;
    localparam logic [3:0] FAULT_OVER_1  = 4'd1;
    localparam logic [3:0] FAULT_OVER_2  = 4'd2;
    localparam logic [3:0] FAULT_OVER_3  = 4'd3;
    localparam logic [3:0] FAULT_OVER_4  = 4'd4;
    localparam logic [3:0] FAULT_UNDER_1 = 4'd5;
    localparam logic [3:0] FAULT_UNDER_2 = 4'd6;
    localparam logic [3:0] FAULT_UNDER_3 = 4'd7;
    localparam logic [3:0] FAULT_UNDER_4 = 4'd8;

    typedef struct packed {
        logic               is_write;
        logic               in_range;
        logic [1:0]         channel;
        logic [4:0]         table_col;
        logic [2:0]         entry_select;
        logic signed [15:0] entry_value;
        logic [7:0]         high_byte;
        logic [7:0]         low_byte;
        logic               low_gain;
    } item_t;

endpackage

// File: src/split_byte_adc_correction.sv
// Throughput: one item per cycle while the output is not stalled; a ten-stage pipeline
// behind a two-entry input queue.
// In-range write items update the tables in the first back stage and produce no result.
// Reset (aresetn low, synchronous) clears the queue, the stage valids and the registers
// raw_mode (0) and black level (100); the coefficient and dark tables are not cleared.
module split_byte_adc_correction
    import sbac_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int COLUMNS  = DEF_COLUMNS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [1:0]         s_channel,
    input  logic [4:0]         s_column,
    input  logic [2:0]         s_entry_select,
    input  logic signed [15:0] s_entry_value,
    input  logic [7:0]         s_high_byte,
    input  logic [7:0]         s_low_byte,
    input  logic               s_wide_frame,
    input  logic               s_low_gain,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_corrected_value,
    output logic [3:0]         m_fault_code,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [11:0]        cfg_data
);

    logic        raw_mode_reg;
    logic [11:0] black_level_reg;
    logic        q_valid, q_pop;
    item_t       q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mode_reg    <= 1'b0;
            black_level_reg <= BLACK_LEVEL_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RAW_MODE:    raw_mode_reg    <= cfg_data[0];
                REG_BLACK_LEVEL: black_level_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    sbac_front #(
        .CHANNELS(CHANNELS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_channel     (s_channel),
        .s_column      (s_column),
        .s_entry_select(s_entry_select),
        .s_entry_value (s_entry_value),
        .s_high_byte   (s_high_byte),
        .s_low_byte    (s_low_byte),
        .s_wide_frame  (s_wide_frame),
        .s_low_gain    (s_low_gain),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    sbac_back #(
        .CHANNELS(CHANNELS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .raw_mode         (raw_mode_reg),
        .black_level      (black_level_reg),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_corrected_value(m_corrected_value),
        .m_fault_code     (m_fault_code)
    );

endmodule

// File: src/sbac_front.sv
module sbac_front
    import sbac_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int COLUMNS  = DEF_COLUMNS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [1:0]         s_channel,
    input  logic [4:0]         s_column,
    input  logic [2:0]         s_entry_select,
    input  logic signed [15:0] s_entry_value,
    input  logic [7:0]         s_high_byte,
    input  logic [7:0]         s_low_byte,
    input  logic               s_wide_frame,
    input  logic               s_low_gain,
    output logic               q_valid,
    output item_t              q_item,
    input  logic               q_pop
);

    item_t      item_in;
    logic [4:0] tcol;
    item_t      q_mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign tcol = (s_operation == OP_SAMPLE && s_wide_frame) ? {1'b0, s_column[4:1]} : s_column;

    always_comb begin
        item_in.is_write     = (s_operation == OP_WRITE);
        item_in.in_range     = ({30'd0, s_channel} < 32'(CHANNELS)) &&
                               ({27'd0, tcol} < 32'(COLUMNS));
        item_in.channel      = s_channel;
        item_in.table_col    = tcol;
        item_in.entry_select = s_entry_select;
        item_in.entry_value  = s_entry_value;
        item_in.high_byte    = s_high_byte;
        item_in.low_byte     = s_low_byte;
        item_in.low_gain     = s_low_gain;
    end

    assign s_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH)) else $error("queue count overrun");
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop on pop");
    a_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not rise on push");
`endif

endmodule

// File: src/sbac_back.sv
module sbac_back
    import sbac_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int COLUMNS  = DEF_COLUMNS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    input  logic        raw_mode,
    input  logic [11:0] black_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_corrected_value,
    output logic [3:0]  m_fault_code
);

    localparam int DEPTH = CHANNELS * COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          en;
    logic [AW-1:0] addr;
    logic          wr_en;

    logic signed [15:0] coef_rd_reg [NUM_TERMS];
    logic signed [15:0] dark_rd_reg [NUM_DARK];

    logic       v1_reg, r1_reg, lg1_reg;
    logic [7:0] hb1_reg, lb1_reg;

    assign en    = !m_valid || m_ready;
    assign q_pop = en && q_valid;
    assign addr  = AW'(AW'(q_item.channel) * AW'(COLUMNS) + AW'(q_item.table_col));
    assign wr_en = q_pop && q_item.is_write && q_item.in_range;

    for (genvar t = 0; t < NUM_TERMS; t++) begin : g_coef
        logic signed [15:0] mem [DEPTH];
        always_ff @(posedge aclk) begin
            if (en) begin
                if (wr_en && q_item.entry_select == 3'(t)) begin
                    mem[addr] <= q_item.entry_value;
                end
                coef_rd_reg[t] <= mem[addr];
            end
        end
    end

    for (genvar j = 0; j < NUM_DARK; j++) begin : g_dark
        logic signed [15:0] mem [DEPTH];
        always_ff @(posedge aclk) begin
            if (en) begin
                if (wr_en && q_item.entry_select == SEL_LOW_DARK + 3'(j)) begin
                    mem[addr] <= q_item.entry_value;
                end
                dark_rd_reg[j] <= mem[addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg  <= q_item.in_range;
            hb1_reg <= q_item.high_byte;
            lb1_reg <= q_item.low_byte;
            lg1_reg <= q_item.low_gain;
        end
    end

    // stage 2: term select, k*hb
    logic signed [15:0] cs [NUM_TERMS];
    logic signed [15:0] k_s, h_s, dark_s;
    logic signed [16:0] b_base, h_half, b_s;
    logic signed [24:0] kp_s;
    logic [7:0]         hbi;
    logic               small_s;

    always_comb begin
        for (int t = 0; t < NUM_TERMS; t++) begin
            cs[t] = r1_reg ? coef_rd_reg[t] : 16'sd0;
        end
        small_s = (hb1_reg < 8'd16);
        h_s     = cs[TERM_H];
        k_s     = (hb1_reg < 8'd128) ? cs[TERM_K] : cs[TERM_K2];
        b_base  = (hb1_reg < 8'd128) ? 17'(cs[TERM_B]) : 17'(cs[TERM_B2]);
        h_half  = (17'(h_s) + $signed({16'd0, h_s[15]})) >>> 1;
        b_s     = small_s ? b_base + h_half : b_base;
        kp_s    = k_s * $signed({1'b0, hb1_reg});
        hbi     = (hb1_reg > 8'd128) ? 8'd64 + {1'b0, hb1_reg[7:1]} : hb1_reg;
        dark_s  = r1_reg ? (lg1_reg ? dark_rd_reg[0] : dark_rd_reg[1]) : 16'sd0;
    end

    logic               v2_reg, small2_reg;
    logic signed [24:0] kp2_reg;
    logic signed [16:0] b2_reg;
    logic signed [15:0] c2_reg, h2_reg, dark2_reg;
    logic [8:0]         span2_reg;
    logic [7:0]         hb2_reg, lb2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            small2_reg <= small_s;
            kp2_reg    <= kp_s;
            b2_reg     <= b_s;
            c2_reg     <= cs[TERM_C];
            h2_reg     <= h_s;
            dark2_reg  <= dark_s;
            span2_reg  <= SAW_SPAN - {1'b0, hbi};
            hb2_reg    <= hb1_reg;
            lb2_reg    <= lb1_reg;
        end
    end

    // stage 3: offset divisions, sawtooth gain
    logic [24:0]        kp_abs;
    logic [9:0]         q0;
    logic [15:0]        r0;
    logic [9:0]         qk;
    logic signed [10:0] kq;
    logic signed [17:0] b_sum;
    logic signed [10:0] bq;
    logic signed [11:0] ioff1;
    logic signed [16:0] h_ext;
    logic [16:0]        h_abs;
    logic [33:0]        h_prod;
    logic signed [16:0] h10, c_s;

    always_comb begin
        kp_abs = kp2_reg[24] ? 25'(-kp2_reg) : 25'(kp2_reg);
        q0     = kp_abs[24:15];
        r0     = {1'b0, kp_abs[14:0]} + {6'd0, q0};
        qk     = q0 + 10'(r0 >= K_SCALE_M1);
        kq     = kp2_reg[24] ? -$signed({1'b0, qk}) : $signed({1'b0, qk});
        b_sum  = 18'(b2_reg) + (b2_reg[16] ? 18'sd127 : 18'sd0);
        bq     = b_sum[17:7];
        ioff1  = 12'(kq) + 12'(bq);
        h_ext  = 17'(h2_reg);
        h_abs  = h_ext[16] ? 17'(-h_ext) : 17'(h_ext);
        h_prod = h_abs * RECIP_10;
        h10    = h_ext[16] ? -$signed({2'b0, h_prod[33:19]}) : $signed({2'b0, h_prod[33:19]});
        c_s    = 17'(c2_reg) + (small2_reg ? h10 : 17'sd0);
    end

    logic               v3_reg;
    logic signed [11:0] ioff3_reg;
    logic signed [12:0] d3_reg;
    logic signed [16:0] c3_reg;
    logic [8:0]         span3_reg;
    logic [7:0]         hb3_reg, lb3_reg;
    logic signed [15:0] dark3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ioff3_reg <= ioff1;
            d3_reg    <= $signed({5'd0, lb2_reg}) + 13'(ioff1) - 13'sd128;
            c3_reg    <= c_s;
            span3_reg <= span2_reg;
            hb3_reg   <= hb2_reg;
            lb3_reg   <= lb2_reg;
            dark3_reg <= dark2_reg;
        end
    end

    // stage 4, 5: sawtooth product
    logic               v4_reg, v5_reg;
    logic signed [29:0] m4_reg;
    logic signed [39:0] saw5_reg;
    logic [8:0]         span4_reg;
    logic signed [11:0] ioff4_reg, ioff5_reg;
    logic [7:0]         hb4_reg, lb4_reg, hb5_reg, lb5_reg;
    logic signed [15:0] dark4_reg, dark5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m4_reg    <= d3_reg * c3_reg;
            span4_reg <= span3_reg;
            ioff4_reg <= ioff3_reg;
            hb4_reg   <= hb3_reg;
            lb4_reg   <= lb3_reg;
            dark4_reg <= dark3_reg;
            saw5_reg  <= m4_reg * $signed({1'b0, span4_reg});
            ioff5_reg <= ioff4_reg;
            hb5_reg   <= hb4_reg;
            lb5_reg   <= lb4_reg;
            dark5_reg <= dark4_reg;
        end
    end

    // stage 6: divide by 2048*225, reciprocal estimate
    logic [39:0] saw_abs;
    logic [27:0] y_s;
    logic [55:0] y_prod;

    always_comb begin
        saw_abs = saw5_reg[39] ? 40'(-saw5_reg) : 40'(saw5_reg);
        y_s     = saw_abs[38:11];
        y_prod  = y_s * RECIP_225;
    end

    logic               v6_reg, neg6_reg;
    logic [27:0]        y6_reg;
    logic [20:0]        q6_reg;
    logic signed [11:0] ioff6_reg;
    logic [7:0]         hb6_reg, lb6_reg;
    logic signed [15:0] dark6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg6_reg  <= saw5_reg[39];
            y6_reg    <= y_s;
            q6_reg    <= y_prod[55:35];
            ioff6_reg <= ioff5_reg;
            hb6_reg   <= hb5_reg;
            lb6_reg   <= lb5_reg;
            dark6_reg <= dark5_reg;
        end
    end

    // stage 7: quotient correction
    logic [28:0]        qm, rem;
    logic               fix;
    logic [20:0]        qc;
    logic signed [22:0] ioff7;

    always_comb begin
        qm    = {q6_reg, 8'd0} - {3'd0, q6_reg, 5'd0} + {8'd0, q6_reg};
        rem   = {1'b0, y6_reg} - qm;
        fix   = (rem >= SAW_DIV_LO);
        qc    = q6_reg + 21'(fix);
        ioff7 = 23'(ioff6_reg) +
                (neg6_reg ? -$signed({2'b0, qc}) : $signed({2'b0, qc}));
    end

    logic               v7_reg;
    logic [8:0]         rem7_reg;
    logic signed [22:0] ioff7_reg;
    logic [7:0]         hb7_reg, lb7_reg;
    logic signed [15:0] dark7_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rem7_reg  <= fix ? 9'(rem - SAW_DIV_LO) : rem[8:0];
            ioff7_reg <= ioff7;
            hb7_reg   <= hb6_reg;
            lb7_reg   <= lb6_reg;
            dark7_reg <= dark6_reg;
        end
    end

    // stage 8: low byte clamp, check terms
    logic signed [23:0] lb_raw;
    logic [7:0]         lbc, lbp;

    always_comb begin
        lb_raw = $signed({16'd0, lb7_reg}) + 24'(ioff7_reg);
        if (lb_raw > 24'sd255) begin
            lbc = 8'd255;
        end else if (lb_raw < 24'sd0) begin
            lbc = 8'd0;
        end else begin
            lbc = lb_raw[7:0];
        end
        lbp = {hb7_reg[3:0], 4'h7};
    end

    logic               v8_reg;
    logic [7:0]         lbc8_reg, hb8_reg;
    logic signed [23:0] lbpc8_reg;
    logic signed [9:0]  qerr8_reg;
    logic signed [15:0] dark8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lbc8_reg  <= lbc;
            hb8_reg   <= hb7_reg;
            lbpc8_reg <= $signed({16'd0, lbp}) - 24'(ioff7_reg);
            qerr8_reg <= $signed({2'd0, lbp}) - $signed({2'd0, lbc});
            dark8_reg <= dark7_reg;
        end
    end

    // stage 9: plausibility check
    logic [3:0] fault;

    always_comb begin
        if (lbpc8_reg > LBPC_OVER_HARD) begin
            fault = FAULT_OVER_1;
        end else if (lbpc8_reg > LBPC_OVER && qerr8_reg > QERR_1) begin
            fault = FAULT_OVER_2;
        end else if (lbpc8_reg > LBPC_OVER_SOFT && qerr8_reg > QERR_2) begin
            fault = FAULT_OVER_3;
        end else if (qerr8_reg > QERR_3) begin
            fault = FAULT_OVER_4;
        end else if (lbpc8_reg < LBPC_UNDER_HARD) begin
            fault = FAULT_UNDER_1;
        end else if (lbpc8_reg < LBPC_UNDER && qerr8_reg < -QERR_1) begin
            fault = FAULT_UNDER_2;
        end else if (lbpc8_reg < LBPC_UNDER_SOFT && qerr8_reg < -QERR_2) begin
            fault = FAULT_UNDER_3;
        end else if (qerr8_reg < -QERR_3) begin
            fault = FAULT_UNDER_4;
        end else begin
            fault = FAULT_NONE;
        end
    end

    logic               v9_reg;
    logic [3:0]         fault9_reg;
    logic [11:0]        res9_reg;
    logic signed [15:0] dark9_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            fault9_reg <= fault;
            res9_reg   <= (fault != FAULT_NONE) ? {hb8_reg, 4'h7} : {hb8_reg[7:4], lbc8_reg};
            dark9_reg  <= dark8_reg;
        end
    end

    // stage 10: dark management, output register
    logic signed [17:0] dsum;
    logic [15:0]        value_s;
    logic               raw_out_reg;

    always_comb begin
        dsum = $signed({6'd0, res9_reg}) - 18'(dark9_reg) + $signed({6'd0, black_level});
        if (raw_mode) begin
            value_s = {4'd0, res9_reg};
        end else if (dsum < 18'sd0) begin
            value_s = 16'd0;
        end else begin
            value_s = dsum[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_corrected_value <= value_s;
            m_fault_code      <= fault9_reg;
            raw_out_reg       <= raw_mode;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else if (en) begin
            v1_reg  <= q_valid && !q_item.is_write;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            m_valid <= v9_reg;
        end
    end

`ifndef SYNTHESIS
    a_fault_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_fault_code <= FAULT_UNDER_4) else $error("fault code out of range");
    a_saw_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v7_reg |-> rem7_reg < 9'(SAW_DIV_LO)) else $error("sawtooth quotient not corrected");
    a_fault_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && raw_out_reg && m_fault_code != FAULT_NONE) |->
        m_corrected_value[3:0] == 4'h7) else $error("fault replacement value wrong");
`endif

endmodule

// File: test/tb.sv
`default_nettype none

module tb;
    import sbac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH        = DEF_CHANNELS;
    localparam int NCOL       = DEF_COLUMNS;
    localparam int DRAIN_WAIT = 24;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_LEN   = 200;

    typedef struct {
        logic [15:0] value;
        logic [3:0]  fault;
    } sample_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_operation;
    logic [1:0]         s_channel;
    logic [4:0]         s_column;
    logic [2:0]         s_entry_select;
    logic signed [15:0] s_entry_value;
    logic [7:0]         s_high_byte;
    logic [7:0]         s_low_byte;
    logic               s_wide_frame;
    logic               s_low_gain;
    logic               m_valid;
    logic               m_ready;
    logic [15:0]        m_corrected_value;
    logic [3:0]         m_fault_code;
    logic               cfg_wr_en;
    logic               cfg_index;
    logic [11:0]        cfg_data;

    int             coef_tbl [NCH][NCOL][NUM_TERMS];
    int             dark_tbl [NCH][NCOL][NUM_DARK];
    bit             raw_sel;
    int             pedestal;
    sample_result_t pending_results[$];
    int             errors;
    int             quiet_cycles;
    bit             gaps_on;
    bit             hold_request;

    split_byte_adc_correction dut (.*);

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic logic signed [15:0] pick_entry();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3, 4: return 16'($signed($urandom_range(0, 800)) - 400);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int table_term(int ch, int col, int term);
        if (col >= NCOL) return 0;
        return coef_tbl[ch][col][term];
    endfunction

    function automatic int table_dark(int ch, int col, int which);
        if (col >= NCOL) return 0;
        return dark_tbl[ch][col][which];
    endfunction

    function automatic sample_result_t correct_sample(int ch, int col, int hb, int lb,
                                                      bit wide, bit lowg);
        sample_result_t res;
        int     nd, c, h, k, b, ioff, lbc, hbi, lbp, lbpc, qerr, value;
        logic [3:0] fault;
        longint saw;
        nd = wide ? (col >> 1) : col;
        c  = table_term(ch, nd, TERM_C);
        h  = table_term(ch, nd, TERM_H);
        if (hb < 16) begin
            k = table_term(ch, nd, TERM_K);
            b = table_term(ch, nd, TERM_B) + h / 2;
            c = c + h / 10;
        end else if (hb < 128) begin
            k = table_term(ch, nd, TERM_K);
            b = table_term(ch, nd, TERM_B);
        end else begin
            k = table_term(ch, nd, TERM_K2);
            b = table_term(ch, nd, TERM_B2);
        end
        ioff = (k * hb) / 32767 + b / 128;
        lbc  = lb + ioff;
        hbi  = (hb > 128) ? 128 + (hb - 128) / 2 : hb;
        saw  = longint'(lbc - 128) * longint'(c) * longint'(300 - hbi);
        ioff += int'(saw / longint'(12 * 300 * 128));
        lbc  = lb + ioff;
        if (lbc > 255) lbc = 255;
        else if (lbc < 0) lbc = 0;
        lbp  = (hb % 16) * 16 + 7;
        lbpc = lbp - ioff;
        qerr = lbp - lbc;
        if (lbpc > LBPC_OVER_HARD) fault = FAULT_OVER_1;
        else if (lbpc > LBPC_OVER && qerr > QERR_1) fault = FAULT_OVER_2;
        else if (lbpc > LBPC_OVER_SOFT && qerr > QERR_2) fault = FAULT_OVER_3;
        else if (qerr > QERR_3) fault = FAULT_OVER_4;
        else if (lbpc < LBPC_UNDER_HARD) fault = FAULT_UNDER_1;
        else if (lbpc < LBPC_UNDER && qerr < -QERR_1) fault = FAULT_UNDER_2;
        else if (lbpc < LBPC_UNDER_SOFT && qerr < -QERR_2) fault = FAULT_UNDER_3;
        else if (qerr < -QERR_3) fault = FAULT_UNDER_4;
        else fault = FAULT_NONE;
        value = (fault != FAULT_NONE) ? hb * 16 + 7 : (hb / 16) * 256 + lbc;
        if (!raw_sel) begin
            value = value - table_dark(ch, nd, lowg ? 0 : 1) + pedestal;
            if (value < 0) value = 0;
        end
        res.value = value[15:0];
        res.fault = fault;
        return res;
    endfunction

    task automatic send(logic op, int ch, int col, int sel, logic signed [15:0] val,
                        int hb, int lb, bit wide, bit lowg);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_channel      <= 2'(ch);
        s_column       <= 5'(col);
        s_entry_select <= 3'(sel);
        s_entry_value  <= val;
        s_high_byte    <= 8'(hb);
        s_low_byte     <= 8'(lb);
        s_wide_frame   <= wide;
        s_low_gain     <= lowg;
        do @(posedge aclk); while (!s_ready);
        if (op == OP_SAMPLE) begin
            pending_results.push_back(correct_sample(ch, col, hb, lb, wide, lowg));
        end else if (col < NCOL) begin
            if (sel < NUM_TERMS) coef_tbl[ch][col][sel] = val;
            else dark_tbl[ch][col][sel - NUM_TERMS] = val;
        end
    endtask

    task automatic write_entry(int ch, int col, int sel, logic signed [15:0] val);
        send(OP_WRITE, ch, col, sel, val, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    task automatic correct(int ch, int col, int hb, int lb, bit wide, bit lowg);
        send(OP_SAMPLE, ch, col, $urandom_range(0, 7), 16'($urandom), hb, lb, wide, lowg);
    endtask

    task automatic random_sample();
        bit wide;
        int col, hb;
        wide = $urandom_range(0, 1);
        if ($urandom_range(0, 19) == 0) col = $urandom_range(wide ? 24 : 12, 31);
        else col = $urandom_range(0, wide ? 23 : 11);
        case ($urandom_range(0, 5))
            0: hb = $urandom_range(0, 15);
            1: hb = $urandom_range(126, 130);
            default: hb = $urandom_range(0, 255);
        endcase
        correct($urandom_range(0, 3), col, hb, $urandom_range(0, 255), wide,
                $urandom_range(0, 1));
    endtask

    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_reg(logic idx, logic [11:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RAW_MODE) raw_sel = data[0];
        else pedestal = data;
    endtask

    task automatic test_table_load();
        for (int ch = 0; ch < NCH; ch++)
            for (int col = 0; col < NCOL; col++)
                for (int sel = 0; sel < NUM_TERMS + NUM_DARK; sel++)
                    write_entry(ch, col, sel, pick_entry());
    endtask

    task automatic test_ignored_writes();
        write_entry(0, NCOL, TERM_K, 16'sh7fff);
        write_entry(3, 31, SEL_LOW_DARK, 16'sh8000);
        write_entry(2, 20, TERM_C, 16'sh1234);
        correct(0, NCOL - 1, 100, 50, 1'b0, 1'b1);
        correct(3, 2 * NCOL - 1, 200, 200, 1'b1, 1'b0);
    endtask

    task automatic test_directed_samples();
        int hbs[8] = '{0, 15, 16, 127, 128, 129, 254, 255};
        foreach (hbs[i]) correct(i % NCH, i, hbs[i], (i % 2) ? 255 : 0, 1'b0, i[0]);
        write_entry(1, 3, TERM_H, 16'sh7fff);
        write_entry(1, 3, TERM_C, 16'sh7fff);
        correct(1, 3, 5, 0, 1'b0, 1'b1);
        correct(1, 7, 5, 255, 1'b1, 1'b0);
        write_entry(1, 3, TERM_K, 16'sh8000);
        write_entry(1, 3, TERM_B, 16'sh8000);
        correct(1, 3, 127, 0, 1'b0, 1'b1);
        correct(2, 12, 255, 255, 1'b0, 1'b0);
        correct(2, 24, 0, 0, 1'b1, 1'b1);
        correct(0, 31, 128, 128, 1'b1, 1'b0);
    endtask

    task automatic test_registers();
        quiesce();
        set_reg(REG_RAW_MODE, 12'd1);
        repeat (6) random_sample();
        quiesce();
        set_reg(REG_RAW_MODE, 12'd0);
        set_reg(REG_BLACK_LEVEL, 12'd0);
        repeat (6) random_sample();
        quiesce();
        set_reg(REG_BLACK_LEVEL, 12'd4095);
        repeat (6) random_sample();
    endtask

    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 3) == 0)
                    write_entry($urandom_range(0, 3), $urandom_range(NCOL, 31),
                                $urandom_range(0, 7), pick_entry());
                else
                    write_entry($urandom_range(0, 3), $urandom_range(0, NCOL - 1),
                                $urandom_range(0, 7), pick_entry());
            end else begin
                random_sample();
            end
        end
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (60) random_sample();
        gaps_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        sample_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d fault=%0d", $realtime,
                         m_corrected_value, m_fault_code);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_corrected_value !== want.value) begin
                    $display("%0t: corrected_value expected %0d actual %0d", $realtime,
                             want.value, m_corrected_value);
                    errors++;
                end
                if (m_fault_code !== want.fault) begin
                    $display("%0t: fault_code expected %0d actual %0d", $realtime,
                             want.fault, m_fault_code);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("split_byte_adc_correction test failed");
            $finish;
        end
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_WRITE;
        s_channel      = '0;
        s_column       = '0;
        s_entry_select = '0;
        s_entry_value  = '0;
        s_high_byte    = '0;
        s_low_byte     = '0;
        s_wide_frame   = 1'b0;
        s_low_gain     = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_RAW_MODE;
        cfg_data       = '0;
        raw_sel        = 1'b0;
        pedestal       = BLACK_LEVEL_RESET;
        errors         = 0;
        quiet_cycles   = 0;
        gaps_on        = 1'b1;
        hold_request   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_table_load();
        test_ignored_writes();
        test_directed_samples();
        test_registers();
        quiesce();
        set_reg(REG_RAW_MODE, 12'd0);
        set_reg(REG_BLACK_LEVEL, 12'($urandom_range(0, 4095)));
        test_random_traffic(400);
        test_backpressure();
        quiesce();
        set_reg(REG_RAW_MODE, 12'd1);
        gaps_on = 1'b0;
        test_random_traffic(250);
        gaps_on = 1'b1;
        test_random_traffic(100);
        quiesce();
        set_reg(REG_RAW_MODE, 12'd0);
        set_reg(REG_BLACK_LEVEL, 12'd4095);
        test_random_traffic(300);
        quiesce();

        if (errors == 0) begin
            $display("split_byte_adc_correction test passed");
        end else begin
            $display("split_byte_adc_correction test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
